// ===== rtl/grid_maze_router_unit_macros.svh =====
// assertion macros of the grid maze router checker
`ifndef GRID_MAZE_ROUTER_UNIT_MACROS_SVH
`define GRID_MAZE_ROUTER_UNIT_MACROS_SVH

// property checked out of reset, on clk and rst of the enclosing scope
`define GMR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("grid maze router check failed");

// property checked at every edge, reset included
`define GMR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("grid maze router check failed during reset");

`endif

// ===== rtl/gmr_pkg.sv =====
// shared constants, word types and codes of the grid maze router
`default_nettype none

package gmr_pkg;

  // sizing
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int QUEUE_DEPTH = 16384;
  localparam int MAX_POINTS  = 64;

  localparam int COORD_W     = 6;
  localparam int CELL_AW     = 2 * COORD_W;
  localparam int CELL_DEPTH  = 1 << CELL_AW;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int NPT_W       = $clog2(MAX_POINTS + 1);
  localparam int DIM_W       = 7;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int CAP_W       = 16;
  localparam int DEM_W       = 16;
  localparam int BASE_W      = 17;
  localparam int COST_W      = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_H_CAPACITY  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_V_CAPACITY  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_COST   = 3'd4;

  typedef enum logic [1:0] {
    KIND_ROUTE    = 2'd0,
    KIND_RIP      = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_BUMP     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic               monotonic;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COST_W-1:0]  total_overflow;
    logic               last;
    logic               truncated;
  } out_word_t;

  // request to the edge cost unit
  typedef struct packed {
    logic [DEM_W-1:0]  demand;
    logic [DEM_W-1:0]  history;
    logic [CAP_W-1:0]  capacity;
    logic [BASE_W-1:0] base;
  } edge_req_t;

  // entries of the cell and edge stores
  typedef struct packed {
    logic              reached;
    logic [1:0]        from;
    logic [COST_W-1:0] cost;
  } cell_entry_t;

  typedef struct packed {
    logic [DEM_W-1:0] demand;
    logic [DEM_W-1:0] history;
  } edge_entry_t;

endpackage

`default_nettype wire

// ===== rtl/gmr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module gmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gmr_edge_cost.sv =====
// edge cost unit: restoring divider, fifth power by repeated multiply, history scale
`default_nettype none

module gmr_edge_cost import gmr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  edge_req_t         req,
  output logic              done,
  output logic [COST_W-1:0] cost
);

  typedef enum logic [2:0] {E_IDLE, E_DIV, E_MUL, E_SAT, E_HIST, E_SUM} estate_t;

  estate_t           st;
  edge_req_t         req_q;
  logic [32:0]       num;
  logic [DEM_W-1:0]  rem;
  logic [32:0]       quo;
  logic [5:0]        bitcnt;
  logic [COST_W-1:0] r;
  logic [COST_W-1:0] p;
  logic [63:0]       prod;
  logic [1:0]        mcnt;

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        fits;
  logic [32:0] q_fin;
  logic [49:0] total;

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem, num[32]};
    fits    = rem_sh >= {1'b0, req_q.capacity};
    rem_sub = rem_sh - {1'b0, req_q.capacity};
    q_fin   = {quo[31:0], fits};
    total   = 50'(req_q.base) + 50'(prod[47:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= E_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        E_IDLE: begin
          if (start) begin
            req_q  <= req;
            num    <= {17'(req.demand) + 17'd1, 16'd0};
            rem    <= '0;
            bitcnt <= '0;
            st     <= E_DIV;
          end
        end
        E_DIV: begin
          rem    <= fits ? rem_sub[DEM_W-1:0] : rem_sh[DEM_W-1:0];
          quo    <= q_fin;
          num    <= {num[31:0], 1'b0};
          bitcnt <= bitcnt + 6'd1;
          if (bitcnt == 6'd32) begin
            r    <= q_fin[32] ? '1 : q_fin[31:0];
            p    <= q_fin[32] ? '1 : q_fin[31:0];
            mcnt <= '0;
            st   <= E_MUL;
          end
        end
        E_MUL: begin
          prod <= 64'(p) * 64'(r);
          st   <= E_SAT;
        end
        // rescale and saturate the running power
        E_SAT: begin
          p    <= (|prod[63:48]) ? '1 : prod[47:16];
          mcnt <= mcnt + 2'd1;
          st   <= (mcnt == 2'd3) ? E_HIST : E_MUL;
        end
        E_HIST: begin
          prod <= {16'd0, 48'(req_q.history) * 48'(p)};
          st   <= E_SUM;
        end
        E_SUM: begin
          cost <= (|total[49:32]) ? '1 : total[31:0];
          done <= 1'b1;
          st   <= E_IDLE;
        end
        default: st <= E_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_maze_router_unit.sv =====
// grid maze router top level: control sequencer over the cell, edge and wavefront stores
//
// One item is taken at a time; in_stall stays high until it is done, for a route
// or an overflow report until its last result word is loaded. After reset the edge
// stores are swept once to demand zero, history one, and no item is taken meanwhile.
// A route clears the cell store, then pops the wavefront queue, costing each
// neighbour inside the grid with the divider and four multiply steps of the edge
// cost unit, then traces back. Overflow report and history bump sweep all 4096
// positions of the edge stores. A rip decrements the demand of each segment edge.
// Result words wait in an output register.
`default_nettype none

module grid_maze_router_unit import gmr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_SEED, ST_POP, ST_QDAT, ST_CDAT, ST_NB, ST_NBDAT,
    ST_COST, ST_CAND, ST_TCHK, ST_TCHKW, ST_TLOOP, ST_TRD, ST_TCORN, ST_TEDGE,
    ST_TINC, ST_TSRC, ST_TLAST, ST_FAIL, ST_RIP, ST_RIPW, ST_OVRD, ST_OVACC,
    ST_OVOUT, ST_BURD, ST_BUWR
  } state_t;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // configuration registers
  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [CAP_W-1:0]  h_capacity;
  logic [CAP_W-1:0]  v_capacity;
  logic [BASE_W-1:0] base_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      h_capacity  <= 16'd1;
      v_capacity  <= 16'd1;
      base_cost   <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        CFG_H_CAPACITY:  h_capacity  <= (cfg_data[CAP_W-1:0] == '0) ? 16'd1 :
                                        cfg_data[CAP_W-1:0];
        CFG_V_CAPACITY:  v_capacity  <= (cfg_data[CAP_W-1:0] == '0) ? 16'd1 :
                                        cfg_data[CAP_W-1:0];
        CFG_BASE_COST:   base_cost   <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_t             state;
  logic [COORD_W-1:0] sx, sy, tx, ty;
  logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [AREA_W-1:0]  area;
  logic               rip_vert;
  logic [COORD_W-1:0] rip_x, rip_y, rip_j, rip_t;
  logic [CELL_AW-1:0] cur;
  dir_t               dir;
  logic [COST_W-1:0]  cost_c, to_cost, cand;
  logic               to_reached;
  logic [QUEUE_AW-1:0] head, tail;
  logic [QCNT_W-1:0]  qcount;
  logic [CELL_AW-1:0] sweep;
  logic [AREA_W-1:0]  steps;
  logic [1:0]         tr_d;
  logic               corner, prev_axis, prev_v, trunc;
  logic [NPT_W-1:0]   npts;
  logic [COORD_W-1:0] pend_x, pend_y;
  logic [COST_W-1:0]  acc;

  // memory ports
  cell_entry_t         c_rd, c_wdata;
  logic                c_we;
  logic [CELL_AW-1:0]  c_raddr, c_waddr;
  edge_entry_t         h_rd, v_rd, h_wdata, v_wdata;
  logic                h_we, v_we;
  logic [CELL_AW-1:0]  e_addr;
  logic [CELL_AW-1:0]  q_rd, q_wdata;
  logic                q_we;

  logic              ec_done;
  logic [COST_W-1:0] ec_cost;
  edge_req_t         ec_req;

  // effective grid size and clamped coordinates
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] csx, csy, ctx, cty;

  function automatic logic [COORD_W-1:0] clamp_c(input logic [COORD_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    if ({1'b0, v} >= lim) return COORD_W'(lim - 7'd1);
    else return v;
  endfunction

  function automatic logic [QUEUE_AW-1:0] q_next(input logic [QUEUE_AW-1:0] ptr);
    if (ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) return '0;
    else return ptr + 1'b1;
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? '1 : s[COST_W-1:0];
  endfunction

  always_comb begin
    w_eff = (grid_width < 7'd2) ? 7'd2 :
            (grid_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width;
    h_eff = (grid_height < 7'd2) ? 7'd2 :
            (grid_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height;
    csx = clamp_c(in_word.src_x, w_eff);
    csy = clamp_c(in_word.src_y, h_eff);
    ctx = clamp_c(in_word.dst_x, w_eff);
    cty = clamp_c(in_word.dst_y, h_eff);
  end

  // neighbour of the popped cell
  logic [COORD_W-1:0] cx, cy;
  logic               nb_ok, nb_v;
  logic [CELL_AW-1:0] nb_to, nb_e;

  always_comb begin
    cx   = cur[COORD_W-1:0];
    cy   = cur[CELL_AW-1:COORD_W];
    nb_v = (dir == DIR_DOWN) || (dir == DIR_UP);
    unique case (dir)
      DIR_DOWN: begin
        nb_ok = (cy != lo_y) && (cy != '0);
        nb_to = {cy - 1'b1, cx};
        nb_e  = {cy - 1'b1, cx};
      end
      DIR_UP: begin
        nb_ok = (cy != hi_y) && (({1'b0, cy} + 7'd1) < h_eff);
        nb_to = {cy + 1'b1, cx};
        nb_e  = cur;
      end
      DIR_RIGHT: begin
        nb_ok = (cx != hi_x) && (({1'b0, cx} + 7'd1) < w_eff);
        nb_to = {cy, cx + 1'b1};
        nb_e  = cur;
      end
      default: begin
        nb_ok = (cx != lo_x) && (cx != '0);
        nb_to = {cy, cx - 1'b1};
        nb_e  = {cy, cx - 1'b1};
      end
    endcase
  end

  // trace-back step from the stored direction
  logic               tr_v;
  logic [CELL_AW-1:0] tr_e, tr_next;

  always_comb begin
    tr_v = (tr_d == DIR_DOWN) || (tr_d == DIR_UP);
    unique case (tr_d)
      DIR_DOWN: begin
        tr_e    = cur;
        tr_next = {cy + 1'b1, cx};
      end
      DIR_UP: begin
        tr_e    = {cy - 1'b1, cx};
        tr_next = {cy - 1'b1, cx};
      end
      DIR_RIGHT: begin
        tr_e    = {cy, cx - 1'b1};
        tr_next = {cy, cx - 1'b1};
      end
      default: begin
        tr_e    = cur;
        tr_next = {cy, cx + 1'b1};
      end
    endcase
  end

  // edge sweep position and which edges exist there
  logic [COORD_W-1:0] sw_x, sw_y;
  logic               h_in, v_in, h_over, v_over;
  logic [DEM_W-1:0]   th, tv;
  logic [COST_W+1:0]  ov_sum;

  always_comb begin
    sw_x   = sweep[COORD_W-1:0];
    sw_y   = sweep[CELL_AW-1:COORD_W];
    h_in   = (({1'b0, sw_x} + 7'd1) < w_eff) && ({1'b0, sw_y} < h_eff);
    v_in   = (({1'b0, sw_y} + 7'd1) < h_eff) && ({1'b0, sw_x} < w_eff);
    h_over = h_in && (h_rd.demand > h_capacity);
    v_over = v_in && (v_rd.demand > v_capacity);
    th     = h_over ? (h_rd.demand - h_capacity) : '0;
    tv     = v_over ? (v_rd.demand - v_capacity) : '0;
    ov_sum = {2'b00, acc} + 34'(th) + 34'(tv);
  end

  // relaxation outcome
  logic improve, q_room, out_free;

  always_comb begin
    improve  = !to_reached || (to_cost > cand);
    q_room   = qcount < QCNT_W'(QUEUE_DEPTH);
    out_free = !out_valid || !out_stall;
  end

  // edge store address and writes
  always_comb begin
    case (state) inside
      ST_NB, ST_NBDAT:   e_addr = nb_e;
      ST_TEDGE, ST_TINC: e_addr = tr_e;
      ST_RIP, ST_RIPW:   e_addr = rip_vert ? {rip_j, rip_x} : {rip_y, rip_j};
      default:           e_addr = sweep;
    endcase
    h_we    = 1'b0;
    v_we    = 1'b0;
    h_wdata = h_rd;
    v_wdata = v_rd;
    case (state)
      ST_INIT: begin
        h_we    = 1'b1;
        v_we    = 1'b1;
        h_wdata = '{demand: '0, history: 16'd1};
        v_wdata = '{demand: '0, history: 16'd1};
      end
      ST_TINC: begin
        h_we = !tr_v;
        v_we = tr_v;
        h_wdata.demand = (h_rd.demand != '1) ? h_rd.demand + 1'b1 : h_rd.demand;
        v_wdata.demand = (v_rd.demand != '1) ? v_rd.demand + 1'b1 : v_rd.demand;
      end
      ST_RIPW: begin
        h_we = !rip_vert;
        v_we = rip_vert;
        h_wdata.demand = (h_rd.demand != '0) ? h_rd.demand - 1'b1 : h_rd.demand;
        v_wdata.demand = (v_rd.demand != '0) ? v_rd.demand - 1'b1 : v_rd.demand;
      end
      ST_BUWR: begin
        h_we = 1'b1;
        v_we = 1'b1;
        if (h_over && (h_rd.history != '1)) h_wdata.history = h_rd.history + 1'b1;
        if (v_over && (v_rd.history != '1)) v_wdata.history = v_rd.history + 1'b1;
      end
      default: ;
    endcase
  end

  // cell store and queue ports
  always_comb begin
    case (state)
      ST_QDAT: c_raddr = q_rd;
      ST_NB:   c_raddr = nb_to;
      ST_TCHK: c_raddr = {ty, tx};
      default: c_raddr = cur;
    endcase
    c_we    = 1'b0;
    c_waddr = nb_to;
    c_wdata = '{reached: 1'b1, from: dir, cost: cand};
    q_we    = 1'b0;
    q_wdata = nb_to;
    case (state)
      ST_CLR: begin
        c_we    = 1'b1;
        c_waddr = sweep;
        c_wdata = '0;
      end
      ST_SEED: begin
        c_we    = 1'b1;
        c_waddr = {sy, sx};
        c_wdata = '{reached: 1'b1, from: 2'd0, cost: '0};
        q_we    = 1'b1;
        q_wdata = {sy, sx};
      end
      ST_CAND: begin
        c_we = improve;
        q_we = improve && q_room;
      end
      default: ;
    endcase
  end

  // edge cost request
  always_comb begin
    ec_req.demand   = nb_v ? v_rd.demand : h_rd.demand;
    ec_req.history  = nb_v ? v_rd.history : h_rd.history;
    ec_req.capacity = nb_v ? v_capacity : h_capacity;
    ec_req.base     = base_cost;
  end

  assign in_stall = (state != ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      qcount    <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) state <= ST_IDLE;
        end
        // take an item and latch its clamped fields
        ST_IDLE: begin
          if (in_valid) begin
            sx     <= csx;
            sy     <= csy;
            tx     <= ctx;
            ty     <= cty;
            lo_x   <= in_word.monotonic ? ((csx < ctx) ? csx : ctx) : '0;
            hi_x   <= in_word.monotonic ? ((csx < ctx) ? ctx : csx) : COORD_W'(w_eff - 7'd1);
            lo_y   <= in_word.monotonic ? ((csy < cty) ? csy : cty) : '0;
            hi_y   <= in_word.monotonic ? ((csy < cty) ? cty : csy) : COORD_W'(h_eff - 7'd1);
            area   <= AREA_W'(w_eff) * AREA_W'(h_eff);
            rip_vert <= (csx == ctx);
            rip_x  <= csx;
            rip_y  <= csy;
            if (csx == ctx) begin
              rip_j <= (csy < cty) ? csy : cty;
              rip_t <= (csy < cty) ? cty : csy;
            end else begin
              rip_j <= (csx < ctx) ? csx : ctx;
              rip_t <= (csx < ctx) ? ctx : csx;
            end
            sweep  <= '0;
            head   <= '0;
            tail   <= '0;
            qcount <= '0;
            acc    <= '0;
            unique case (in_word.kind)
              KIND_ROUTE:    state <= ST_CLR;
              KIND_RIP:      state <= ST_RIP;
              KIND_OVERFLOW: state <= ST_OVRD;
              default:       state <= ST_BURD;
            endcase
          end
        end
        ST_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) state <= ST_SEED;
        end
        ST_SEED: begin
          tail   <= q_next(tail);
          qcount <= QCNT_W'(1);
          state  <= ST_POP;
        end
        // wavefront search
        ST_POP: begin
          if (qcount == '0) begin
            state <= ST_TCHK;
          end else begin
            head   <= q_next(head);
            qcount <= qcount - 1'b1;
            state  <= ST_QDAT;
          end
        end
        ST_QDAT: begin
          cur   <= q_rd;
          state <= ST_CDAT;
        end
        ST_CDAT: begin
          cost_c <= c_rd.cost;
          dir    <= DIR_DOWN;
          state  <= ST_NB;
        end
        ST_NB: begin
          if (nb_ok) begin
            state <= ST_NBDAT;
          end else if (dir == DIR_LEFT) begin
            state <= ST_POP;
          end else begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        ST_NBDAT: begin
          to_reached <= c_rd.reached;
          to_cost    <= c_rd.cost;
          state      <= ST_COST;
        end
        ST_COST: begin
          if (ec_done) begin
            cand  <= sat_add(cost_c, ec_cost);
            state <= ST_CAND;
          end
        end
        ST_CAND: begin
          if (improve && q_room) begin
            tail   <= q_next(tail);
            qcount <= qcount + 1'b1;
          end
          if (dir == DIR_LEFT) begin
            state <= ST_POP;
          end else begin
            dir   <= dir_t'(dir + 2'd1);
            state <= ST_NB;
          end
        end
        // trace-back
        ST_TCHK: state <= ST_TCHKW;
        ST_TCHKW: begin
          if (!c_rd.reached) begin
            state <= ST_FAIL;
          end else begin
            pend_x <= tx;
            pend_y <= ty;
            npts   <= NPT_W'(1);
            cur    <= {ty, tx};
            steps  <= '0;
            prev_v <= 1'b0;
            trunc  <= 1'b0;
            state  <= ST_TLOOP;
          end
        end
        ST_TLOOP: begin
          if ((cur == {sy, sx}) || (steps == area)) state <= ST_TSRC;
          else state <= ST_TRD;
        end
        ST_TRD: begin
          tr_d      <= c_rd.from;
          steps     <= steps + 1'b1;
          corner    <= prev_v && (prev_axis != !c_rd.from[1]);
          prev_axis <= !c_rd.from[1];
          prev_v    <= 1'b1;
          state     <= ST_TCORN;
        end
        ST_TCORN: begin
          if (corner && (npts < NPT_W'(MAX_POINTS))) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_word  <= '{point_x: pend_x, point_y: pend_y, total_overflow: '0,
                             last: 1'b0, truncated: 1'b0};
              pend_x    <= cx;
              pend_y    <= cy;
              npts      <= npts + 1'b1;
              state     <= ST_TEDGE;
            end
          end else begin
            if (corner) trunc <= 1'b1;
            state <= ST_TEDGE;
          end
        end
        ST_TEDGE: state <= ST_TINC;
        ST_TINC: begin
          cur   <= tr_next;
          state <= ST_TLOOP;
        end
        ST_TSRC: begin
          if (npts < NPT_W'(MAX_POINTS)) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_word  <= '{point_x: pend_x, point_y: pend_y, total_overflow: '0,
                             last: 1'b0, truncated: 1'b0};
              pend_x    <= sx;
              pend_y    <= sy;
              state     <= ST_TLAST;
            end
          end else begin
            trunc <= 1'b1;
            state <= ST_TLAST;
          end
        end
        ST_TLAST: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= '{point_x: pend_x, point_y: pend_y, total_overflow: '0,
                           last: 1'b1, truncated: trunc};
            state     <= ST_IDLE;
          end
        end
        // target never reached
        ST_FAIL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= '{point_x: tx, point_y: ty, total_overflow: '0,
                           last: 1'b1, truncated: 1'b1};
            state     <= ST_IDLE;
          end
        end
        // segment rip
        ST_RIP: begin
          if (rip_j == rip_t) state <= ST_IDLE;
          else state <= ST_RIPW;
        end
        ST_RIPW: begin
          rip_j <= rip_j + 1'b1;
          state <= ST_RIP;
        end
        // overflow sweep
        ST_OVRD: state <= ST_OVACC;
        ST_OVACC: begin
          acc <= (|ov_sum[COST_W+1:COST_W]) ? '1 : ov_sum[COST_W-1:0];
          if (sweep == '1) begin
            state <= ST_OVOUT;
          end else begin
            sweep <= sweep + 1'b1;
            state <= ST_OVRD;
          end
        end
        ST_OVOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= '{point_x: '0, point_y: '0, total_overflow: acc,
                           last: 1'b1, truncated: 1'b0};
            state     <= ST_IDLE;
          end
        end
        // history bump sweep
        ST_BURD: state <= ST_BUWR;
        ST_BUWR: begin
          if (sweep == '1) begin
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
            state <= ST_BURD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // stores
  gmr_ram #(.WIDTH($bits(cell_entry_t)), .DEPTH(CELL_DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  gmr_ram #(.WIDTH($bits(edge_entry_t)), .DEPTH(CELL_DEPTH)) u_h_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (e_addr),
    .wdata (h_wdata),
    .raddr (e_addr),
    .rdata (h_rd)
  );

  gmr_ram #(.WIDTH($bits(edge_entry_t)), .DEPTH(CELL_DEPTH)) u_v_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (e_addr),
    .wdata (v_wdata),
    .raddr (e_addr),
    .rdata (v_rd)
  );

  gmr_ram #(.WIDTH(CELL_AW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (q_wdata),
    .raddr (head),
    .rdata (q_rd)
  );

  gmr_edge_cost u_edge_cost (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_NBDAT),
    .req   (ec_req),
    .done  (ec_done),
    .cost  (ec_cost)
  );

endmodule

`default_nettype wire

// ===== rtl/gmr_checker.sv =====
// port level checker of the grid maze router, bound to the top level
`default_nettype none
`include "grid_maze_router_unit_macros.svh"

module gmr_checker import gmr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled result word holds
  `GMR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word))

  // one item at a time: busy right after a word is taken
  `GMR_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall)

  // a truncated path is flagged on its final word only
  `GMR_ASSERT(a_trunc_last, out_valid && out_word.truncated |-> out_word.last)

  // words before the final one are path points with no overflow
  `GMR_ASSERT(a_point_no_ov, out_valid && !out_word.last |-> out_word.total_overflow == 0)

  // reset empties the output register
  `GMR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind grid_maze_router_unit gmr_checker u_gmr_checker (.*);

`default_nettype wire
